>>> rtl/cartesian_cylindrical_converter_core_assert.svh
// assertion macros for the coordinate converter
// used by the top level only
`ifndef CARTESIAN_CYLINDRICAL_CONVERTER_CORE_ASSERT_SVH
`define CARTESIAN_CYLINDRICAL_CONVERTER_CORE_ASSERT_SVH
// implication checked on every clock, off in reset
`define CCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the next cycle
`define CCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/ccc_pkg.sv
// package for the coordinate converter: widths, angle constants, arctangent table
// no dependencies
`timescale 1ns / 1ps
package ccc_pkg;
  localparam int CoordWidthDef  = 32;
  localparam int CordicStepsDef = 24;
  // internal angle width, Q30 with room for plus/minus 2 pi
  localparam int AngW = 34;
  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [AngW-1:0] TwoPiQ30  = 34'sd6746518852;
  localparam logic [29:0] GainK = 30'd652032874;

  typedef enum logic {
    REQ_TO_CYL  = 1'b0,
    REQ_TO_CART = 1'b1
  } req_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    logic signed [AngW-1:0] v;
    case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: v = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return v;
  endfunction
endpackage

>>> rtl/ccc_if.sv
// valid/ready channel carrying one three-coordinate item
// depends on nothing
`timescale 1ns / 1ps
interface ccc_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic         req_type;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] c;
  modport source (output valid, req_type, a, b, c, input ready);
  modport sink   (input valid, req_type, a, b, c, output ready);
endinterface

>>> rtl/cartesian_cylindrical_converter_core.sv
// throughput: one item per cycle; a stall freezes the whole pipeline
// three stages reduce the angle, one conditions the item, one per micro-rotation,
// then two for the gain multiply, rounding and saturation
// reset: synchronous active-low rst_n clears all stage valid bits
// depends on ccc_pkg, ccc_if and the assertion macro header
`timescale 1ns / 1ps
`include "cartesian_cylindrical_converter_core_assert.svh"
module cartesian_cylindrical_converter_core #(
  parameter int COORD_WIDTH  = ccc_pkg::CoordWidthDef,
  parameter int CORDIC_STEPS = ccc_pkg::CordicStepsDef
) (
  input  logic clk,
  input  logic rst_n,
  ccc_if.sink   in_ch,
  ccc_if.source out_ch
);
  import ccc_pkg::*;

  localparam int W  = COORD_WIDTH;
  // datapath width: input plus growth through pi turn and cordic gain
  localparam int DW = W + 3;
  localparam int NS = CORDIC_STEPS;
  // stages: 3 angle reduction, 1 prep, NS rotations, gain partial, gain sum/round
  localparam int NST = NS + 6;
  localparam int PW  = DW + 31;
  // angle reduction: quotient estimate |b| * 2^14 / 2pi by reciprocal multiply
  localparam int RecipSh = 50;
  localparam logic [31:0] RecipAng = 32'(64'h7fff_ffff_ffff_ffff / 64'(PiQ30));
  localparam int QW = (W > 20) ? W - 19 : 1;
  localparam int RW = W + 20;

  logic adv;
  logic [NST-1:0] v_r;
  assign adv = !v_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;

  logic signed [DW-1:0]   x_r [0:NS];
  logic signed [DW-1:0]   y_r [0:NS];
  logic signed [AngW-1:0] z_r [0:NS];
  logic                   vec_r [0:NS];
  logic                   zero_r [0:NS];
  logic [W-1:0]           c_r [0:NS];

  // valid bits shift with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_ch.valid};
    end
  end

  // angle reduction pipeline: item fields travel alongside
  req_t                   preq_r [0:2];
  logic [W-1:0]           pa_r [0:2];
  logic [W-1:0]           pb_r [0:2];
  logic [W-1:0]           pc_r [0:2];
  logic [W-1:0]           bmag_r [0:1];
  logic                   bneg_r [0:1];
  logic [QW-1:0]          q_r;
  logic signed [AngW-1:0] tred_r;
  logic [W+31:0]          qprod;
  logic [RW-1:0]          rem0, rem1;
  logic signed [AngW-1:0] tmag, tw;

  assign qprod = (W+32)'(bmag_r[0]) * (W+32)'(RecipAng);

  // remainder of |b| * 2^14 modulo 2pi, signed like b, wrapped into [-pi, pi)
  always_comb begin
    rem0 = (RW'(bmag_r[1]) << 14) - RW'(q_r) * RW'(TwoPiQ30);
    rem1 = (rem0 >= RW'(TwoPiQ30)) ? rem0 - RW'(TwoPiQ30) : rem0;
    tmag = AngW'(rem1);
    if (!bneg_r[1]) tw = (tmag >= PiQ30) ? tmag - TwoPiQ30 : tmag;
    else tw = (tmag > PiQ30) ? TwoPiQ30 - tmag : -tmag;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: magnitude and sign of the angle input
      preq_r[0] <= req_t'(in_ch.req_type);
      pa_r[0]   <= in_ch.a;
      pb_r[0]   <= in_ch.b;
      pc_r[0]   <= in_ch.c;
      bmag_r[0] <= in_ch.b[W-1] ? (~in_ch.b + W'(1)) : in_ch.b;
      bneg_r[0] <= in_ch.b[W-1];
      // stage 2: quotient estimate, low by at most one
      preq_r[1] <= preq_r[0];
      pa_r[1]   <= pa_r[0];
      pb_r[1]   <= pb_r[0];
      pc_r[1]   <= pc_r[0];
      bmag_r[1] <= bmag_r[0];
      bneg_r[1] <= bneg_r[0];
      q_r       <= QW'(qprod >> RecipSh);
      // stage 3: reduced angle
      preq_r[2] <= preq_r[1];
      pa_r[2]   <= pa_r[1];
      pb_r[2]   <= pb_r[1];
      pc_r[2]   <= pc_r[1];
      tred_r    <= tw;
    end
  end

  // input conditioning: half-plane turn by pi for vectoring and for rotation
  logic signed [W-1:0]      ia, ib;
  logic signed [DW-1:0]     x_nxt, y_nxt;
  logic signed [AngW-1:0]   z_nxt;
  always_comb begin
    ia = pa_r[2];
    ib = pb_r[2];
    x_nxt = DW'(ia);
    y_nxt = DW'(ib);
    z_nxt = '0;
    if (preq_r[2] == REQ_TO_CYL) begin
      if (ia < 0) begin
        z_nxt = (ib >= 0) ? PiQ30 : -PiQ30;
        x_nxt = -DW'(ia);
        y_nxt = -DW'(ib);
      end
    end else begin
      y_nxt = '0;
      z_nxt = tred_r;
      if (tred_r > HalfPiQ30) begin
        x_nxt = -DW'(ia);
        z_nxt = tred_r - PiQ30;
      end else if (tred_r < -HalfPiQ30) begin
        x_nxt = -DW'(ia);
        z_nxt = tred_r + PiQ30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= x_nxt;
      y_r[0]    <= y_nxt;
      z_r[0]    <= z_nxt;
      vec_r[0]  <= (preq_r[2] == REQ_TO_CYL);
      zero_r[0] <= (preq_r[2] == REQ_TO_CYL) && (ia == 0) && (ib == 0);
      c_r[0]    <= pc_r[2];
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam int SH = (i < 32) ? i : 31;
    logic pos;
    assign pos = vec_r[i] ? (y_r[i] < 0) : (z_r[i] >= 0);
    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]    <= pos ? x_r[i] - (y_r[i] >>> SH) : x_r[i] + (y_r[i] >>> SH);
        y_r[i+1]    <= pos ? y_r[i] + (x_r[i] >>> SH) : y_r[i] - (x_r[i] >>> SH);
        z_r[i+1]    <= (i < 32) ? (pos ? z_r[i] - atan_q30(i) : z_r[i] + atan_q30(i))
                                : z_r[i];
        vec_r[i+1]  <= vec_r[i];
        zero_r[i+1] <= zero_r[i];
        c_r[i+1]    <= c_r[i];
      end
    end
  end

  // gain correction: split multiply into high and low partial products
  localparam int LB = 16;
  logic signed [PW-1:0]   xh_p_r, xl_p_r, yh_p_r, yl_p_r;
  logic signed [AngW-1:0] zg_r;
  logic                   vecg_r, zerog_r;
  logic [W-1:0]           cg_r;
  logic signed [DW-LB-1:0] xh, yh;
  logic [LB-1:0]           xl, yl;
  assign xh = x_r[NS][DW-1:LB];
  assign xl = x_r[NS][LB-1:0];
  assign yh = y_r[NS][DW-1:LB];
  assign yl = y_r[NS][LB-1:0];
  always_ff @(posedge clk) begin
    if (adv) begin
      xh_p_r  <= PW'(xh) * PW'($signed({1'b0, GainK}));
      xl_p_r  <= PW'($signed({1'b0, xl})) * PW'($signed({1'b0, GainK}));
      yh_p_r  <= PW'(yh) * PW'($signed({1'b0, GainK}));
      yl_p_r  <= PW'($signed({1'b0, yl})) * PW'($signed({1'b0, GainK}));
      zg_r    <= z_r[NS];
      vecg_r  <= vec_r[NS];
      zerog_r <= zero_r[NS];
      cg_r    <= c_r[NS];
    end
  end

  // sum partials, round, saturate
  localparam logic signed [PW-1:0] SatHi = PW'((64'sd1 <<< (W-1)) - 1);
  localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);
  logic signed [PW-1:0]   xs, ys, xg, yg, zq;
  logic signed [AngW-1:0] zr;
  logic [W-1:0]           a_nxt, b_nxt;
  always_comb begin
    xs = (xh_p_r <<< LB) + xl_p_r + (PW'(1) <<< 29);
    ys = (yh_p_r <<< LB) + yl_p_r + (PW'(1) <<< 29);
    xg = xs >>> 30;
    yg = ys >>> 30;
    zr = zg_r + AngW'(8192);
    zq = PW'(zr >>> 14);
    if (xg > SatHi) xg = SatHi;
    else if (xg < SatLo) xg = SatLo;
    if (yg > SatHi) yg = SatHi;
    else if (yg < SatLo) yg = SatLo;
    if (zq > SatHi) zq = SatHi;
    else if (zq < SatLo) zq = SatLo;
    a_nxt = W'(xg);
    b_nxt = vecg_r ? W'(zq) : W'(yg);
    if (zerog_r) begin
      a_nxt = '0;
      b_nxt = '0;
    end
  end

  logic [W-1:0] oa_r, ob_r, oc_r;
  req_t         otype_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      oa_r    <= a_nxt;
      ob_r    <= b_nxt;
      oc_r    <= cg_r;
      otype_r <= vecg_r ? REQ_TO_CYL : REQ_TO_CART;
    end
  end

  assign out_ch.valid    = v_r[NST-1];
  assign out_ch.a        = oa_r;
  assign out_ch.b        = ob_r;
  assign out_ch.c        = oc_r;
  assign out_ch.req_type = otype_r;

  // stall must hold the result in place
  `CCC_ASSERT_NXT(a_hold, out_ch.valid && !out_ch.ready,
                  out_ch.valid && $stable(out_ch.a) && $stable(out_ch.b),
                  "result changed while stalled")
  // ready only drops when the last stage is full
  `CCC_ASSERT_IMP(a_ready, !in_ch.ready, out_ch.valid, "input stalled with empty output")
  // an accepted item sets the first valid bit
  `CCC_ASSERT_NXT(a_enter, in_ch.valid && in_ch.ready, v_r[0], "accepted item lost")
endmodule
